FILE: sv/esd_pkg.sv
`default_nettype none

package esd_pkg;

  // event kinds on the input word
  localparam logic [1:0] FUNC_REQ    = 2'd0;
  localparam logic [1:0] FUNC_STEP   = 2'd1;
  localparam logic [1:0] FUNC_ARRIVE = 2'd2;

  // result actions
  localparam logic [1:0] ACT_UP   = 2'd0;
  localparam logic [1:0] ACT_DOWN = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  localparam int FieldW = 5;

  typedef enum logic [1:0] {
    DIR_STAY = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // controller -> datapath
  typedef struct packed {
    logic       set_req;      // set busy and the requested pending bit
    logic       set_busy;
    logic       scan_start;   // load scan pointer from the cabin floor
    logic       scan_step;
    logic       take_target;  // target <= scan pointer
    logic       clr_busy;
    logic       decide;       // work out travel direction from target
    logic       advance;      // with decide: move the cabin one floor
    logic       serve_clr;    // drop target's pending bit, note it as served
    logic       out_load;
    logic [1:0] act;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic floor_ok;
    logic busy;
    logic scan_hit;
    logic scan_last;
    logic tgt_gt;
    logic tgt_lt;
    logic out_stall;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/esd_dp.sv
`default_nettype none

module esd_dp import esd_pkg::*; #(
  parameter int FLOOR_COUNT = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [FieldW-1:0] floor_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [1:0]             action_o,
  output logic [FieldW-1:0]      served_floor_o,
  output logic [FieldW-1:0]      cab_floor_o,
  output logic                   pending_left_o
);

  localparam int CW = $clog2(FLOOR_COUNT + 1);

  logic [FLOOR_COUNT-1:0] pend_q, pend_d;
  logic [CW-1:0]          cur_q, cur_d;
  logic [CW-1:0]          tgt_q, tgt_d;
  logic [CW-1:0]          served_q, served_d;
  dir_e                   travel_q, travel_d;
  dir_e                   prev_q, prev_d;
  logic                   busy_q, busy_d;
  logic [CW-1:0]          scan_p_q, scan_p_d;
  logic                   scan_up_q, scan_up_d;
  logic                   scan_pass_q, scan_pass_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_act_q;
  logic [FieldW-1:0]      out_served_q, out_cab_q;
  logic                   out_left_q;

  logic [FLOOR_COUNT-1:0] req_mask, tgt_mask, scan_mask;
  logic                   search_up, at_edge;

  always_comb begin
    req_mask  = FLOOR_COUNT'(1) << (floor_i - FieldW'(1));
    tgt_mask  = FLOOR_COUNT'(1) << (tgt_q - CW'(1));
    scan_mask = FLOOR_COUNT'(1) << (scan_p_q - CW'(1));
    search_up = (travel_q == DIR_UP) || ((travel_q == DIR_STAY) && (prev_q != DIR_DOWN));
    at_edge   = scan_up_q ? (scan_p_q == CW'(FLOOR_COUNT)) : (scan_p_q == CW'(1));

    sts_o.floor_ok  = (floor_i != '0) && (int'(floor_i) <= FLOOR_COUNT);
    sts_o.busy      = busy_q;
    sts_o.scan_hit  = |(pend_q & scan_mask);
    sts_o.scan_last = at_edge && scan_pass_q;
    sts_o.tgt_gt    = tgt_q > cur_q;
    sts_o.tgt_lt    = tgt_q < cur_q;
    sts_o.out_stall = out_valid_q && !out_ready_i;
  end

  always_comb begin
    pend_d      = pend_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    served_d    = served_q;
    travel_d    = travel_q;
    prev_d      = prev_q;
    busy_d      = busy_q;
    scan_p_d    = scan_p_q;
    scan_up_d   = scan_up_q;
    scan_pass_d = scan_pass_q;

    if (cmd_i.set_req) begin
      busy_d = 1'b1;
      pend_d = pend_q | req_mask;
    end
    if (cmd_i.set_busy) busy_d = 1'b1;
    if (cmd_i.clr_busy) busy_d = 1'b0;

    if (cmd_i.scan_start) begin
      scan_p_d    = cur_q;
      scan_up_d   = search_up;
      scan_pass_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      if (at_edge) begin
        // end of shaft: second pass from the cabin the other way
        scan_p_d    = cur_q;
        scan_up_d   = !scan_up_q;
        scan_pass_d = 1'b1;
      end else begin
        scan_p_d = scan_up_q ? scan_p_q + CW'(1) : scan_p_q - CW'(1);
      end
    end

    if (cmd_i.take_target) tgt_d = scan_p_q;

    if (cmd_i.decide) begin
      if (tgt_q > cur_q) begin
        travel_d = DIR_UP;
        if (cmd_i.advance) cur_d = cur_q + CW'(1);
      end else if (tgt_q < cur_q) begin
        travel_d = DIR_DOWN;
        if (cmd_i.advance) cur_d = cur_q - CW'(1);
      end else begin
        prev_d   = travel_q;
        travel_d = DIR_STAY;
      end
    end

    if (cmd_i.serve_clr) begin
      pend_d   = pend_q & ~tgt_mask;
      served_d = tgt_q;
    end

    if (cmd_i.out_load)  out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      cur_q       <= CW'(1);
      tgt_q       <= CW'(1);
      served_q    <= '0;
      travel_q    <= DIR_STAY;
      prev_q      <= DIR_STAY;
      busy_q      <= 1'b0;
      scan_p_q    <= CW'(1);
      scan_up_q   <= 1'b1;
      scan_pass_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      served_q    <= served_d;
      travel_q    <= travel_d;
      prev_q      <= prev_d;
      busy_q      <= busy_d;
      scan_p_q    <= scan_p_d;
      scan_up_q   <= scan_up_d;
      scan_pass_q <= scan_pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_act_q    <= cmd_i.act;
      out_served_q <= (cmd_i.act == ACT_STOP) ? FieldW'(served_q) : '0;
      out_cab_q    <= FieldW'(cur_q);
      out_left_q   <= busy_q && (|pend_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_act_q;
  assign served_floor_o = out_served_q;
  assign cab_floor_o    = out_cab_q;
  assign pending_left_o = out_left_q;

`ifndef SYNTH
  a_scan_in_shaft: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (scan_p_q >= CW'(1)) && (scan_p_q <= CW'(FLOOR_COUNT)))
    else $error("scan pointer left the shaft");
  a_req_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_req |=> (|pend_q) && busy_q)
    else $error("request left no pending floor");
  a_stop_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && (cmd_i.act == ACT_STOP) |=> out_served_q != '0)
    else $error("stop reported without a served floor");
`endif

endmodule

`default_nettype wire

FILE: sv/esd_ctrl.sv
`default_nettype none

module esd_ctrl import esd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] func_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SERVE,
    ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic       serve_q, serve_d;   // current scan follows a stop
  logic       adv_q, adv_d;       // cabin advance event
  logic [1:0] act_q, act_d;

  always_comb begin
    cmd_o     = '0;
    cmd_o.act = act_q;
    state_d   = state_q;
    serve_d   = serve_q;
    adv_d     = adv_q;
    act_d     = act_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_REQ: begin
              if (sts_i.floor_ok) begin
                cmd_o.set_req    = 1'b1;
                cmd_o.scan_start = 1'b1;
                serve_d = 1'b0;
                adv_d   = 1'b0;
                state_d = ST_SCAN;
              end
            end
            FUNC_STEP: begin
              cmd_o.set_busy   = 1'b1;
              cmd_o.scan_start = 1'b1;
              serve_d = 1'b0;
              adv_d   = 1'b1;
              state_d = ST_SCAN;
            end
            FUNC_ARRIVE: begin
              if (sts_i.busy) state_d = ST_SERVE;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          cmd_o.take_target = 1'b1;
          if (serve_q) begin
            act_d   = ACT_STOP;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_DECIDE;
          end
        end else if (sts_i.scan_last) begin
          if (serve_q) begin
            cmd_o.clr_busy = 1'b1;
            act_d   = ACT_STOP;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DECIDE: begin
        cmd_o.decide  = 1'b1;
        cmd_o.advance = adv_q;
        act_d = sts_i.tgt_gt ? ACT_UP : ACT_DOWN;
        state_d = (sts_i.tgt_gt || sts_i.tgt_lt) ? ST_EMIT : ST_SERVE;
      end
      ST_SERVE: begin
        cmd_o.serve_clr  = 1'b1;
        cmd_o.scan_start = 1'b1;
        serve_d = 1'b1;
        state_d = ST_SCAN;
      end
      ST_EMIT: begin
        if (!sts_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      serve_q <= 1'b0;
      adv_q   <= 1'b0;
      act_q   <= ACT_STOP;
    end else begin
      state_q <= state_d;
      serve_q <= serve_d;
      adv_q   <= adv_d;
      act_q   <= act_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_stall)
    else $error("result register overwritten");
  a_decide_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECIDE |-> $past(state_q) == ST_SCAN)
    else $error("direction decided without a target scan");
  a_serve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.serve_clr |-> sts_i.busy)
    else $error("stop served while free");
`endif

endmodule

`default_nettype wire

FILE: sv/elevator_scan_dispatcher.sv
`default_nettype none

// Channel | dir | handshake               | word
// event   | in  | in_valid_i/in_ready_o   | func_i floor_i
// result  | out | out_valid_o/out_ready_i | action_o served_floor_o cab_floor_o pending_left_o
//
// One event at a time, in steps: accept, target scan, decision, stop clear, result load; each
// target scan reads one pending bit per cycle. The longest event is a request at the cabin
// floor: it hits at once, is served, then the rescan walks the whole shaft. Dropped words
// (bad floor, spare kind, arrival while free) are taken and left in the idle state; a step
// with nothing pending scans the whole shaft and gives no result. Reset: asynchronous,
// active low; cabin at floor 1, no requests.
// A word waiting on out_ready_i stalls the load state; once loaded the next event gets in.

module elevator_scan_dispatcher import esd_pkg::*; #(
  parameter int FLOOR_COUNT = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        func_i,
  input  wire logic [FieldW-1:0] floor_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             action_o,
  output logic [FieldW-1:0]      served_floor_o,
  output logic [FieldW-1:0]      cab_floor_o,
  output logic                   pending_left_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, scan, decide, serve, emit
  esd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // pending map, cabin/target state, scan pointer and result register
  esd_dp #(
    .FLOOR_COUNT (FLOOR_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .floor_i        (floor_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .action_o       (action_o),
    .served_floor_o (served_floor_o),
    .cab_floor_o    (cab_floor_o),
    .pending_left_o (pending_left_o)
  );

endmodule

`default_nettype wire
